[design/icc_pkg.sv]
// ----------------------------------------------------------------------------
// icc_pkg
// Shared types, constants and the bytewise CRC-32 step of the image chunker.
// ----------------------------------------------------------------------------
package icc_pkg;

   localparam int CHUNK_BYTES = 256;
   localparam int FILL_W      = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;

   localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   localparam logic [1:0] MODE_START  = 2'd0;
   localparam logic [1:0] MODE_DATA   = 2'd1;
   localparam logic [1:0] MODE_FINISH = 2'd2;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_CLOSE = 2'd1,
      KIND_END   = 2'd2,
      KIND_START = 2'd3
   } kind_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] data_byte;
   } req_word_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  byte_out;
      logic [15:0] seq;
      logic        chunk_end;
      logic [31:0] crc_value;
      logic        size_ok;
      logic        last;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_word_type word0;
      rsp_word_type word1;
   } rsp_push_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                            input logic [7:0] data);
      logic [31:0] c;
      c = crc_in ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

[design/image_chunker_with_crc32_core.sv]
// ----------------------------------------------------------------------------
// image_chunker_with_crc32_core
// Splits an image byte stream into numbered chunks and checks it with CRC-32.
// ----------------------------------------------------------------------------
// Usage:
//   req_word carries a mode and a byte; it is taken on an edge with req_valid
//   high and req_stall low. A start word emits a start marker with sequence
//   0, each data word is passed on with its chunk sequence number and a chunk
//   end flag, and a finish word emits an optional close-chunk word and then
//   the end report with the inverted CRC and the size check.
//   rsp_word is offered with rsp_valid and taken when rsp_stall is low.
//   csr_data writes the expected image size (csr_ready is always high); write
//   it only while the block is idle.
// Throughput:
//   Results are registered in a four-word result queue. One word per cycle
//   is taken while req_stall is low; a finish that closes a chunk adds two
//   results, which the output side drains one per cycle while rsp_stall is
//   low. req_stall rises when that queue has fewer than two free slots.
// Reset:
//   Synchronous; clears the queue and sets CRC to all ones, counts to zero
//   and the expected size to zero.
// ----------------------------------------------------------------------------
module image_chunker_with_crc32_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  icc_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output icc_pkg::rsp_word_type rsp_word,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [31:0]           csr_data
);
   import icc_pkg::*;

   logic [31:0]       crc_ff, crc_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [15:0]       seq_ff, seq_in;
   logic [31:0]       total_ff, total_in;
   logic [31:0]       expected_size_ff;
   logic              room_two;
   logic              req_accept;
   logic              full;
   rsp_push_type      push;
   rsp_word_type      blank;

   assign csr_ready  = 1'b1;
   assign req_stall  = !room_two;
   assign req_accept = req_valid && !req_stall;
   assign full       = (fill_ff == FILL_W'(CHUNK_BYTES - 1));

   always_comb begin
      blank = '{kind: KIND_DATA, byte_out: 8'd0, seq: 16'd0, chunk_end: 1'b0,
                crc_value: 32'd0, size_ok: 1'b0, last: 1'b1};
      crc_in   = crc_ff;
      fill_in  = fill_ff;
      seq_in   = seq_ff;
      total_in = total_ff;
      push.count = 2'd0;
      push.word0 = blank;
      push.word1 = blank;
      if (req_accept) begin
         case (req_word.mode)
            MODE_START: begin
               crc_in   = CRC_ALL_ONES;
               fill_in  = '0;
               total_in = '0;
               seq_in   = 16'd1;
               push.count      = 2'd1;
               push.word0.kind = KIND_START;
            end
            MODE_DATA: begin
               crc_in   = crc_byte(crc_ff, req_word.data_byte);
               total_in = (total_ff != 32'hFFFF_FFFF) ? (total_ff + 32'd1) : total_ff;
               fill_in  = full ? '0 : (fill_ff + FILL_W'(1));
               seq_in   = seq_ff + 16'(full);
               push.count          = 2'd1;
               push.word0.byte_out  = req_word.data_byte;
               push.word0.seq       = seq_ff;
               push.word0.chunk_end = full;
            end
            MODE_FINISH: begin
               fill_in = '0;
               if (fill_ff != '0) begin
                  push.count       = 2'd2;
                  push.word0.kind  = KIND_CLOSE;
                  push.word0.seq   = seq_ff;
                  push.word0.last  = 1'b0;
                  push.word1.kind      = KIND_END;
                  push.word1.seq       = seq_ff + 16'd1;
                  push.word1.crc_value = crc_ff ^ CRC_ALL_ONES;
                  push.word1.size_ok   = (total_ff == expected_size_ff);
                  seq_in = seq_ff + 16'd2;
               end else begin
                  push.count           = 2'd1;
                  push.word0.kind      = KIND_END;
                  push.word0.seq       = seq_ff;
                  push.word0.crc_value = crc_ff ^ CRC_ALL_ONES;
                  push.word0.size_ok   = (total_ff == expected_size_ff);
                  seq_in = seq_ff + 16'd1;
               end
            end
            default: begin
               push.count = 2'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff           <= CRC_ALL_ONES;
         fill_ff          <= '0;
         seq_ff           <= '0;
         total_ff         <= '0;
         expected_size_ff <= '0;
      end else begin
         crc_ff   <= crc_in;
         fill_ff  <= fill_in;
         seq_ff   <= seq_in;
         total_ff <= total_in;
         if (csr_valid && csr_ready) begin
            expected_size_ff <= csr_data;
         end
      end
   end

   icc_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room_two  (room_two),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

`ifndef SYNTHESIS
   a_start_seq: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_word.mode == MODE_START) |=> (seq_ff == 16'd1 && fill_ff == '0))
      else $error("start did not restart the sequence");

   a_chunk_wrap: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_word.mode == MODE_DATA && full) |=> fill_ff == '0)
      else $error("fill count not cleared at chunk end");

   a_finish_clear: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_word.mode == MODE_FINISH) |=> fill_ff == '0)
      else $error("fill count not cleared at finish");

   a_total_hold: assert property (@(posedge clock) disable iff (reset)
      (!req_accept) |=> (total_ff == $past(total_ff) && crc_ff == $past(crc_ff)))
      else $error("state changed without an accepted word");
`endif

endmodule

[design/icc_rsp_fifo.sv]
// ----------------------------------------------------------------------------
// icc_rsp_fifo
// Result queue: takes up to two words per cycle, delivers one per cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
module icc_rsp_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  icc_pkg::rsp_push_type push,
   output logic                 room_two,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output icc_pkg::rsp_word_type rsp_word
);
   import icc_pkg::*;

   rsp_word_type                entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]        count_ff, count_in;
   logic [RSP_PTR_W-1:0]        wr_ptr;
   logic                        pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_word  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign room_two  = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));
   assign wr_ptr    = rd_ptr_ff + count_ff[RSP_PTR_W-1:0];

   assign rd_ptr_in = pop ? (rd_ptr_ff + RSP_PTR_W'(1)) : rd_ptr_ff;
   assign count_in  = count_ff + RSP_CNT_W'(push.count) - RSP_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr] <= push.word0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr + RSP_PTR_W'(1)] <= push.word1;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("result queue count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> room_two)
      else $error("result queue written without room");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd0 && pop) |=> count_ff == $past(count_ff) - RSP_CNT_W'(1))
      else $error("result queue count mismatch on pop");
`endif

endmodule

[tb/tb_image_chunker_with_crc32_core.sv]
// ----------------------------------------------------------------------------
// tb_image_chunker_with_crc32_core
// Self-checking bench for the image chunker: a word-level predictor tracks the
// CRC, chunk fill, sequence number and byte count, and every result word is
// matched in order against its prediction. Directed transfers cover the edge
// cases, then random transfers run under several expected sizes, most with
// random gaps and stalls on both sides, and a flat-out run of finish words
// closes the run.
// ----------------------------------------------------------------------------
module tb_image_chunker_with_crc32_core;
   import icc_pkg::*;

   localparam logic [1:0]  MODE_UNUSED        = 2'd3;
   localparam logic [31:0] CRC_REFLECTED_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_SEED           = 32'hFFFF_FFFF;
   localparam int          DRAIN_CYCLES       = 8;
   localparam int          RANDOM_ITEMS       = 1080;
   localparam int          PHASES             = 6;
   localparam int          HOLD_CYCLES        = 300;
   localparam int          HOLD_AFTER         = 400;
   localparam int          TAIL_FINISHES      = 60;
   localparam int          MAX_REPORTS        = 50;
   localparam int          TIMEOUT            = 20_000_000;

   class chunk_crc_scoreboard;
      logic [31:0]  crc_state;
      int           fill_bytes;
      logic [15:0]  next_seq;
      logic [31:0]  byte_count;
      logic [31:0]  size_target;
      rsp_word_type expected_words[$];
      int           errors;

      function new();
         crc_state   = CRC_SEED;
         fill_bytes  = 0;
         next_seq    = '0;
         byte_count  = '0;
         size_target = '0;
         errors      = 0;
      endfunction

      function logic [31:0] crc_step(logic [31:0] c, logic [7:0] d);
         for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (CRC_REFLECTED_POLY & {32{c[0] ^ d[i]}});
         end
         return c;
      endfunction

      function string show(rsp_word_type w);
         return $sformatf("kind=%0d byte=%02h seq=%0d end=%b crc=%08h ok=%b last=%b",
                          w.kind, w.byte_out, w.seq, w.chunk_end, w.crc_value,
                          w.size_ok, w.last);
      endfunction

      function void absorb_word(req_word_type w);
         rsp_word_type r;
         r = '0;
         case (w.mode)
            MODE_START: begin
               crc_state  = CRC_SEED;
               fill_bytes = 0;
               byte_count = '0;
               r.kind     = KIND_START;
               r.last     = 1'b1;
               expected_words.push_back(r);
               next_seq   = 16'd1;
            end
            MODE_DATA: begin
               crc_state = crc_step(crc_state, w.data_byte);
               if (byte_count != '1) byte_count++;
               fill_bytes++;
               r.kind      = KIND_DATA;
               r.byte_out  = w.data_byte;
               r.seq       = next_seq;
               r.chunk_end = (fill_bytes >= CHUNK_BYTES);
               r.last      = 1'b1;
               expected_words.push_back(r);
               if (r.chunk_end) begin
                  fill_bytes = 0;
                  next_seq++;
               end
            end
            MODE_FINISH: begin
               if (fill_bytes > 0) begin
                  r.kind = KIND_CLOSE;
                  r.seq  = next_seq;
                  expected_words.push_back(r);
                  next_seq++;
                  fill_bytes = 0;
               end
               r           = '0;
               r.kind      = KIND_END;
               r.seq       = next_seq;
               r.crc_value = ~crc_state;
               r.size_ok   = (byte_count == size_target);
               r.last      = 1'b1;
               expected_words.push_back(r);
               next_seq++;
            end
            default: begin
            end
         endcase
      endfunction

      function void match_word(rsp_word_type got);
         rsp_word_type want;
         if (expected_words.size() == 0) begin
            if (errors < MAX_REPORTS)
               $display("%0t: unexpected result, expected none, actual %s", $time, show(got));
            errors++;
            return;
         end
         want = expected_words.pop_front();
         if (got.kind !== want.kind || got.byte_out !== want.byte_out ||
             got.seq !== want.seq || got.chunk_end !== want.chunk_end ||
             got.crc_value !== want.crc_value || got.size_ok !== want.size_ok ||
             got.last !== want.last) begin
            if (errors < MAX_REPORTS)
               $display("%0t: result mismatch, expected %s, actual %s",
                        $time, show(want), show(got));
            errors++;
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;
   logic         csr_valid;
   logic         csr_ready;
   logic [31:0]  csr_data;

   chunk_crc_scoreboard sb;
   int gap_odds;
   int items_sent;
   int results_seen;
   int stall_left;
   bit hold_done;

   image_chunker_with_crc32_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(TIMEOUT);
      $display("tb_image_chunker_with_crc32_core NOT OK");
      $finish;
   end

   // result side: check, then pick the stall for the next cycle
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            sb.match_word(rsp_word);
            results_seen++;
         end
         if (!hold_done && results_seen >= HOLD_AFTER && req_valid) begin
            hold_done  = 1'b1;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && gap_odds != 0 &&
                      $urandom_range(1, 100) <= gap_odds) begin
            stall_left = $urandom_range(1, 8);
         end
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   task automatic send_word(input logic [1:0] m, input logic [7:0] b);
      req_word_type w;
      w.mode      = m;
      w.data_byte = b;
      if (gap_odds != 0 && $urandom_range(1, 100) <= gap_odds) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      sb.absorb_word(w);
      if (m != MODE_UNUSED) items_sent++;
   endtask

   task automatic wait_drained();
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_expected_size(input logic [31:0] size);
      req_valid <= 1'b0;
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= size;
      do @(posedge clock); while (!csr_ready);
      csr_valid      <= 1'b0;
      sb.size_target = size;
   endtask

   // mostly well-formed transfers; some lack a start or a finish, some are noise
   task automatic run_transfers(input int budget);
      int stop_at;
      int n;
      int r;
      stop_at = items_sent + budget;
      while (items_sent < stop_at) begin
         r = $urandom_range(0, 9);
         if (r == 0) begin
            send_word(2'($urandom_range(0, 3)), 8'($urandom));
         end else begin
            if (r != 1) send_word(MODE_START, 8'($urandom));
            case ($urandom_range(0, 5))
               0, 1:    n = (sb.size_target <= 3 * CHUNK_BYTES) ? int'(sb.size_target)
                                                               : $urandom_range(0, 24);
               2:       n = CHUNK_BYTES - 1 + $urandom_range(0, 2);
               default: n = $urandom_range(0, 24);
            endcase
            repeat (n) send_word(MODE_DATA, 8'($urandom));
            if (r != 2) begin
               send_word(MODE_FINISH, 8'($urandom));
               if ($urandom_range(0, 4) == 0) send_word(MODE_FINISH, 8'($urandom));
            end
         end
      end
   endtask

   initial begin
      logic [31:0] size;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_word     <= '0;
      rsp_stall    <= 1'b0;
      csr_valid    <= 1'b0;
      csr_data     <= '0;
      gap_odds     = 15;
      items_sent   = 0;
      results_seen = 0;
      stall_left   = 0;
      hold_done    = 1'b0;
      sb           = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      set_expected_size(32'd3);
      send_word(MODE_DATA, 8'h00);
      send_word(MODE_DATA, 8'hFF);
      send_word(MODE_FINISH, 8'h00);
      send_word(MODE_FINISH, 8'hFF);
      send_word(MODE_UNUSED, 8'hFF);
      send_word(MODE_UNUSED, 8'h00);
      send_word(MODE_START, 8'hAA);
      send_word(MODE_DATA, 8'h00);
      send_word(MODE_DATA, 8'hFF);
      send_word(MODE_DATA, 8'hA5);
      send_word(MODE_FINISH, 8'h5A);
      send_word(MODE_FINISH, 8'h00);
      send_word(MODE_START, 8'hFF);
      send_word(MODE_FINISH, 8'hFF);
      send_word(MODE_DATA, 8'h80);
      send_word(MODE_DATA, 8'h01);
      send_word(MODE_FINISH, 8'h55);
      send_word(MODE_UNUSED, 8'h3C);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       size = 32'd0;
            1:       size = CHUNK_BYTES;
            2:       size = $urandom_range(1, 40);
            3:       size = $urandom;
            4:       size = CHUNK_BYTES + 1;
            default: size = 32'hFFFF_FFFF;
         endcase
         gap_odds = (p == 2) ? 0 : ((p == 4) ? 40 : 15);
         set_expected_size(size);
         run_transfers(RANDOM_ITEMS / PHASES);
      end

      // last stretch runs flat out
      gap_odds = 0;
      send_word(MODE_START, 8'($urandom));
      repeat (3) send_word(MODE_DATA, 8'($urandom));
      repeat (TAIL_FINISHES) send_word(MODE_FINISH, 8'($urandom));
      req_valid <= 1'b0;
      wait_drained();

      if (sb.errors == 0 && sb.expected_words.size() == 0) begin
         $display("tb_image_chunker_with_crc32_core OK");
      end else begin
         $display("tb_image_chunker_with_crc32_core NOT OK");
      end
      $finish;
   end

endmodule

[sim.f]
design/icc_pkg.sv
design/icc_rsp_fifo.sv
design/image_chunker_with_crc32_core.sv
tb/tb_image_chunker_with_crc32_core.sv
